// ----- rtl/emt_pkg.sv -----
// ----------------------------------------------------------------------------
// emt_pkg
// Shared types, widths and helpers for the energy-momentum tensor sum.
// ----------------------------------------------------------------------------
package emt_pkg;

  localparam int EnergyWidth  = 31;
  localparam int MomWidth     = 32;
  localparam int EventWidth   = 31;
  localparam int SumWidth     = 48;
  localparam int StatusWidth  = 2;
  localparam int NumSums      = 10;
  localparam int NumPairs     = 6;
  localparam int ProdWidth    = 2 * MomWidth;
  localparam int DefAccWidth  = 48;

  // status bit positions
  localparam int StatSat  = 0;
  localparam int StatZero = 1;

  // one classified particle, as it sits in the queue
  typedef struct packed {
    logic [EnergyWidth-1:0]           energy;
    logic [2:0][MomWidth-1:0]         mag;
    logic [2:0]                       neg;
    logic                             zero_e;
    logic [EventWidth-1:0]            event_number;
    logic                             last;
  } emt_item_t;

  // queue handshake toward the back part
  typedef struct packed {
    logic valid;
    logic pop;
  } emt_q_ctl_t;

  // first and second momentum index of quadratic term k
  function automatic logic [1:0] pair_first(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_second(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0:       r = 2'd0;
      3'd1, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/energy_momentum_tensor_accumulator.sv -----
// ----------------------------------------------------------------------------
// energy_momentum_tensor_accumulator
// Sums the ten energy-momentum tensor components over the particles of an
// event and emits them on the last particle.
// ----------------------------------------------------------------------------
// Input channel: one particle per beat (energy, mom_x/y/z in Q15.16, event
// number, last flag) on in_valid / in_stall. Output channel: one beat per
// event on out_valid / out_stall with the ten Q31.16 sums, the event number
// and status (bit0 saturation, bit1 zero energy).
// The front queues up to two classified particles. For each particle the
// back adds the energy and momentum sums and, for a nonzero energy, forms
// each of the six p_i*p_j/E terms in turn (one multiply, 64 radix-2
// divider steps, one accumulate) on the shared bit-serial divider; it
// takes the next particle only when done with the last. A closing particle
// then passes through the emit state, which loads the output register.
// Reset clears the accumulators, status, queue and output valid.
// While the receiver stalls the result holds; the back waits at the next
// event end and the queue fills, then in_stall rises.
// ----------------------------------------------------------------------------
module energy_momentum_tensor_accumulator
  import emt_pkg::*;
#(
  parameter int ACCUMULATOR_WIDTH = DefAccWidth
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [EnergyWidth-1:0] energy,
  input  logic [MomWidth-1:0]    mom_x,
  input  logic [MomWidth-1:0]    mom_y,
  input  logic [MomWidth-1:0]    mom_z,
  input  logic [EventWidth-1:0]  event_number,
  input  logic                   last_particle,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SumWidth-1:0]    sum_t00,
  output logic [SumWidth-1:0]    sum_t01,
  output logic [SumWidth-1:0]    sum_t02,
  output logic [SumWidth-1:0]    sum_t03,
  output logic [SumWidth-1:0]    sum_t11,
  output logic [SumWidth-1:0]    sum_t12,
  output logic [SumWidth-1:0]    sum_t13,
  output logic [SumWidth-1:0]    sum_t22,
  output logic [SumWidth-1:0]    sum_t23,
  output logic [SumWidth-1:0]    sum_t33,
  output logic [EventWidth-1:0]  event_out,
  output logic [StatusWidth-1:0] status_bits
);

  emt_q_ctl_t                       qc;
  emt_item_t                        q_item;
  logic [NumSums-1:0][SumWidth-1:0] sums;

  emt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .energy        (energy),
    .mom_x         (mom_x),
    .mom_y         (mom_y),
    .mom_z         (mom_z),
    .event_number  (event_number),
    .last_particle (last_particle),
    .q_pop         (qc.pop),
    .q_valid       (qc.valid),
    .q_item        (q_item)
  );

  emt_back #(
    .ACCUMULATOR_WIDTH (ACCUMULATOR_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (qc.valid),
    .q_pop       (qc.pop),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sums        (sums),
    .event_out   (event_out),
    .status_bits (status_bits)
  );

  assign sum_t00 = sums[0];
  assign sum_t01 = sums[1];
  assign sum_t02 = sums[2];
  assign sum_t03 = sums[3];
  assign sum_t11 = sums[4];
  assign sum_t12 = sums[5];
  assign sum_t13 = sums[6];
  assign sum_t22 = sums[7];
  assign sum_t23 = sums[8];
  assign sum_t33 = sums[9];

endmodule

// ----- rtl/emt_front.sv -----
// ----------------------------------------------------------------------------
// emt_front
// Accepts particle beats, splits momenta into sign and magnitude, flags zero
// energy and holds classified items in a two-entry queue.
// ----------------------------------------------------------------------------
module emt_front
  import emt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [EnergyWidth-1:0] energy,
  input  logic [MomWidth-1:0]    mom_x,
  input  logic [MomWidth-1:0]    mom_y,
  input  logic [MomWidth-1:0]    mom_z,
  input  logic [EventWidth-1:0]  event_number,
  input  logic                   last_particle,
  input  logic                   q_pop,
  output logic                   q_valid,
  output emt_item_t              q_item
);

  emt_item_t        slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic [1:0]       count_next;
  emt_item_t        cls;
  logic             push;
  logic [2:0][MomWidth-1:0] mom;

  assign mom = {mom_z, mom_y, mom_x};

  // classify the incoming beat
  always_comb begin
    cls.energy       = energy;
    cls.zero_e       = (energy == '0);
    cls.event_number = event_number;
    cls.last         = last_particle;
    for (int i = 0; i < 3; i++) begin
      cls.neg[i] = mom[i][MomWidth-1];
      cls.mag[i] = mom[i][MomWidth-1] ? (~mom[i] + 1'b1) : mom[i];
    end
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !q_pop) begin
      count_next = count + 2'd1;
    end else if (!push && q_pop) begin
      count_next = count - 2'd1;
    end
  end

  // advance pointers and store beats
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

endmodule

// ----- rtl/emt_back.sv -----
// ----------------------------------------------------------------------------
// emt_back
// Sequencer that adds the linear terms, forms each p_i*p_j/E with one
// multiplier and a bit-serial divider, saturates into the accumulators and
// emits the event sums through an output register.
// ----------------------------------------------------------------------------
module emt_back
  import emt_pkg::*;
#(
  parameter int ACCUMULATOR_WIDTH = DefAccWidth
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  emt_item_t                       q_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [NumSums-1:0][SumWidth-1:0] sums,
  output logic [EventWidth-1:0]           event_out,
  output logic [StatusWidth-1:0]          status_bits
);

  localparam int Aw = ACCUMULATOR_WIDTH;
  localparam logic [64:0] LimPos = (65'd1 << (Aw - 1)) - 65'd1;
  localparam logic [Aw-1:0] AccMax = {1'b0, {(Aw-1){1'b1}}};
  localparam logic [Aw-1:0] AccMin = {1'b1, {(Aw-1){1'b0}}};

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LIN  = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_ACC  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t                 state;
  emt_item_t              item;
  logic [Aw-1:0]          acc [NumSums];
  logic                   sat_seen;
  logic                   zero_seen;
  logic [2:0]             pair;
  logic [5:0]             step;
  logic [ProdWidth-1:0]   dvd;
  logic [EnergyWidth-1:0] rem;
  logic                   emit_fire;

  // saturating add: {overflow, value}
  function automatic logic [Aw:0] sat_add(input logic [Aw-1:0] a,
                                          input logic [Aw-1:0] t);
    logic [Aw:0] s;
    logic [Aw:0] r;
    s = {a[Aw-1], a} + {t[Aw-1], t};
    if (s[Aw] != s[Aw-1]) begin
      r = {1'b1, s[Aw] ? AccMin : AccMax};
    end else begin
      r = {1'b0, s[Aw-1:0]};
    end
    return r;
  endfunction

  // linear terms
  logic [3:0][Aw-1:0] lin_term;
  logic [3:0][Aw:0]   lin_sum;
  always_comb begin
    lin_term[0] = Aw'(item.energy);
    for (int i = 0; i < 3; i++) begin
      lin_term[i+1] = Aw'($signed(item.neg[i] ? (~item.mag[i] + 1'b1) : item.mag[i]));
    end
    for (int i = 0; i < 4; i++) begin
      lin_sum[i] = sat_add(acc[i], lin_term[i]);
    end
  end

  // one divider step
  logic [EnergyWidth:0]   cur;
  logic                   ge;
  logic [EnergyWidth-1:0] rem_next;
  assign cur      = {rem, dvd[ProdWidth-1]};
  assign ge       = (cur >= {1'b0, item.energy});
  assign rem_next = ge ? EnergyWidth'(cur - {1'b0, item.energy}) : cur[EnergyWidth-1:0];

  // clamp quotient and add into its accumulator
  logic           qneg;
  logic           qover;
  logic [Aw-1:0]  qterm;
  logic [3:0]     acc_idx;
  logic [Aw:0]    quad_sum;
  always_comb begin
    qneg    = item.neg[pair_first(pair)] ^ item.neg[pair_second(pair)];
    qover   = qneg ? ({1'b0, dvd} > (LimPos + 65'd1)) : ({1'b0, dvd} > LimPos);
    if (qover) begin
      qterm = qneg ? AccMin : AccMax;
    end else begin
      qterm = qneg ? (~dvd[Aw-1:0] + 1'b1) : dvd[Aw-1:0];
    end
    acc_idx  = 4'd4 + {1'b0, pair};
    quad_sum = sat_add(acc[acc_idx], qterm);
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign emit_fire = (state == S_EMIT) && (!out_valid || !out_stall);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sat_seen  <= 1'b0;
      zero_seen <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NumSums; i++) begin
        acc[i] <= '0;
      end
    end else begin
      // raise valid on emit, drop it once the beat is taken
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            item  <= q_item;
            state <= S_LIN;
          end
        end
        S_LIN: begin
          for (int i = 0; i < 4; i++) begin
            acc[i] <= lin_sum[i][Aw-1:0];
          end
          if (lin_sum[0][Aw] || lin_sum[1][Aw] || lin_sum[2][Aw] || lin_sum[3][Aw]) begin
            sat_seen <= 1'b1;
          end
          pair <= 3'd0;
          if (item.zero_e) begin
            zero_seen <= 1'b1;
            state     <= item.last ? S_EMIT : S_IDLE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          dvd   <= item.mag[pair_first(pair)] * item.mag[pair_second(pair)];
          rem   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          dvd  <= {dvd[ProdWidth-2:0], ge};
          rem  <= rem_next;
          step <= step + 6'd1;
          if (step == 6'd63) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          acc[acc_idx] <= quad_sum[Aw-1:0];
          if (qover || quad_sum[Aw]) begin
            sat_seen <= 1'b1;
          end
          if (pair == 3'(NumPairs - 1)) begin
            state <= item.last ? S_EMIT : S_IDLE;
          end else begin
            pair  <= pair + 3'd1;
            state <= S_MUL;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            sat_seen  <= 1'b0;
            zero_seen <= 1'b0;
            for (int i = 0; i < NumSums; i++) begin
              acc[i] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // load the result register
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      for (int i = 0; i < NumSums; i++) begin
        sums[i] <= SumWidth'($signed(acc[i]));
      end
      event_out   <= item.event_number;
      status_bits <= {zero_seen, sat_seen};
    end
  end

  // the divider never runs on a zero energy
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (item.energy != '0))
    else $error("divider running with zero energy");

  // quadratic term index stays in range
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC || state == S_MUL || state == S_DIV) |-> (pair < 3'(NumPairs)))
    else $error("pair index out of range");

  // an emitted event leaves acc[0] and the flags cleared, with out_valid set
  assert property (@(posedge clk) disable iff (rst)
    emit_fire |=> (acc[0] == '0 && !sat_seen && !zero_seen && out_valid))
    else $error("state not cleared after emit");

endmodule
